[rtl/tbrl_pkg.sv]
// ---------------------------------------------------------------------------
// Token bucket rate limiter package
// Shared widths, register codes, reset values, refill arithmetic constants
// and the controller-to-datapath command bundle.
// ---------------------------------------------------------------------------
package tbrl_pkg;

  localparam int unsigned DEF_NUM_USERS = 256;
  localparam int unsigned DEF_TIME_BITS = 48;

  localparam int USER_W      = 8;
  localparam int NOW_W       = 48;
  localparam int TOKEN_W     = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RATE     = CFG_INDEX_W'(1);

  localparam logic [TOKEN_W-1:0] CAPACITY_RESET = TOKEN_W'(5);
  localparam logic [TOKEN_W-1:0] RATE_RESET     = TOKEN_W'(1);

  // Elapsed time at or beyond 2^ELAPSED_W ms with a nonzero rate always
  // earns more tokens than any bucket holds.
  localparam int ELAPSED_W = 30;
  localparam int PROD_W    = ELAPSED_W + TOKEN_W;

  // A product of at least 1000 * 2^17 earns 2^17 tokens or more: saturate.
  localparam logic [PROD_W-1:0] SAT_PRODUCT = PROD_W'(131072000);

  // Below SAT_PRODUCT: floor(p / 1000) = floor((p >> 3) / 125), with the
  // quotient by 125 estimated through a reciprocal and fixed up once.
  localparam int QUOT_IN_W   = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;
  localparam int EST_W       = 18;
  localparam int MULT_W      = QUOT_IN_W + RECIP_W;
  localparam int REM_W       = 25;
  localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(134217);
  localparam logic [REM_W-1:0]   DIV_125   = REM_W'(125);

  typedef struct packed {
    logic load;    // latch the request, start the bucket read
    logic calc1;   // merge bucket entry, elapsed time times rate
    logic calc2;   // saturation check, reciprocal estimate
    logic commit;  // refill, spend, write back, present the result
  } tbrl_cmd_t;

endpackage

[rtl/tbrl_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module tbrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tbrl_ctrl.sv]
// ---------------------------------------------------------------------------
// Token bucket controller
// Sequences one request through the datapath and owns the output valid.
// ---------------------------------------------------------------------------
module tbrl_ctrl
  import tbrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output tbrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CALC1  = 2'd1;
  localparam logic [1:0] S_CALC2  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  assign in_stall   = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.calc1  = (state == S_CALC1);
  assign cmd.calc2  = (state == S_CALC2);
  // hold the finished transaction until the output register is free
  assign cmd.commit = (state == S_COMMIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CALC1;
      S_CALC1:  state_next = S_CALC2;
      S_CALC2:  state_next = S_COMMIT;
      S_COMMIT: if (cmd.commit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/tbrl_dp.sv]
// ---------------------------------------------------------------------------
// Token bucket datapath
// Configuration registers, bucket store, refill arithmetic and result.
// ---------------------------------------------------------------------------
module tbrl_dp
  import tbrl_pkg::*;
#(
  parameter int unsigned NUM_USERS = DEF_NUM_USERS,
  parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tbrl_cmd_t              cmd,
  input  logic [USER_W-1:0]      user_index,
  input  logic [NOW_W-1:0]       now_ms,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   allowed
);

  // only users 0..255 can be addressed; time lives in the low bits of now_ms
  localparam int unsigned DEPTH = (NUM_USERS < 256) ? NUM_USERS : 256;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;
  localparam int ENT_W = TOKEN_W + TW;

  logic [TOKEN_W-1:0] capacity;
  logic [TOKEN_W-1:0] rate;

  logic [USER_W-1:0]  user_q;
  logic [TW-1:0]      now_q;
  logic               reject;
  logic [DEPTH-1:0]   valid_bits;

  logic [ENT_W-1:0]   rd_entry;
  logic [ENT_W-1:0]   wr_entry;
  logic               ram_we;
  logic [IW-1:0]      rd_idx;
  logic [IW-1:0]      idx;

  // stage 1
  logic [TOKEN_W-1:0] tok_src;
  logic [TW-1:0]      time_src;
  logic [TW-1:0]      elapsed;
  logic [ELAPSED_W-1:0] elapsed_lo;
  logic [TOKEN_W-1:0] tok_base;
  logic [TW-1:0]      time_base;
  logic [PROD_W-1:0]  prod;
  logic               big;

  // stage 2
  logic [QUOT_IN_W-1:0] quot_in;
  logic [MULT_W-1:0]    recip_mult;
  logic [QUOT_IN_W-1:0] quot_in_q;
  logic [EST_W-1:0]     est;
  logic                 sat;

  // stage 3
  logic [REM_W-1:0]     rem;
  logic [EST_W-1:0]     add;
  logic                 earned;
  logic [EST_W-1:0]     sum;
  logic [TOKEN_W-1:0]   filled;
  logic [TOKEN_W-1:0]   tok_mid;
  logic                 spend;
  logic [TOKEN_W-1:0]   tok_final;
  logic [TW-1:0]        time_final;

  assign rd_idx = user_index[IW-1:0];
  assign idx    = user_q[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      rate     <= RATE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CAPACITY) begin
        capacity <= cfg_data;
      end else if (cfg_index == REG_RATE) begin
        rate <= cfg_data;
      end
    end
  end

  tbrl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (ram_we) begin
      valid_bits[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      user_q <= user_index;
      now_q  <= now_ms[TW-1:0];
      reject <= (32'(user_index) >= NUM_USERS);
    end
  end

  // Stage 1: a new bucket starts full and stamped now, so it earns nothing
  always_comb begin
    tok_src    = valid_bits[idx] ? rd_entry[ENT_W-1:TW] : capacity;
    time_src   = valid_bits[idx] ? rd_entry[TW-1:0] : now_q;
    elapsed    = (now_q >= time_src) ? (now_q - time_src) : '0;
    elapsed_lo = ELAPSED_W'(elapsed);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      tok_base  <= tok_src;
      time_base <= time_src;
      prod      <= PROD_W'(elapsed_lo) * PROD_W'(rate);
      big       <= ((elapsed >> ELAPSED_W) != '0) && (rate != '0);
    end
  end

  // Stage 2
  assign quot_in    = prod[QUOT_IN_W+2:3];
  assign recip_mult = MULT_W'(quot_in) * MULT_W'(RECIP_125);

  always_ff @(posedge clk) begin
    if (cmd.calc2) begin
      quot_in_q <= quot_in;
      est       <= recip_mult[RECIP_SHIFT +: EST_W];
      sat       <= big || (prod >= SAT_PRODUCT);
    end
  end

  // Stage 3: the estimate is low by at most one
  always_comb begin
    rem    = REM_W'(quot_in_q) - (REM_W'(est) * DIV_125);
    add    = est + EST_W'(rem >= DIV_125);
    earned = sat || (add != '0);
    sum    = EST_W'(tok_base) + add;
    filled = (sat || (sum > EST_W'(capacity))) ? capacity : sum[TOKEN_W-1:0];
    tok_mid    = earned ? filled : tok_base;
    spend      = (tok_mid != '0);
    tok_final  = tok_mid - TOKEN_W'(spend);
    time_final = earned ? now_q : time_base;
  end

  assign ram_we   = cmd.commit && !reject;
  assign wr_entry = {tok_final, time_final};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      allowed <= spend && !reject;
    end
  end

endmodule

[rtl/token_bucket_rate_limiter.sv]
// ---------------------------------------------------------------------------
// Token bucket rate limiter
// Per-user token bucket policer with millisecond refill.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_stall with user_index and now_ms. A new
//   user gets a full bucket stamped with now_ms; a known user earns
//   floor(elapsed * refill_rate / 1000) tokens, capped at bucket_capacity.
//   Result channel: out_valid/out_stall with allowed (1 = token spent).
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 capacity,
//   1 refill rate) and cfg_data; writes to other indexes are dropped.
//   Write configuration only while no request is in flight.
// Timing:
//   A request passes through bucket read, rate multiply, reciprocal
//   divide by 1000, then refill and write back of the bucket entry; the
//   result is registered at write back. One request is in flight at a
//   time; the next is taken while the previous result waits.
// Reset:
//   Clears all bucket valid marks at once and loads capacity 5, rate 1.
// Stall:
//   A stalled result holds; a finished request then waits before write
//   back, and in_stall stays high until the result register frees up.
// ---------------------------------------------------------------------------
module token_bucket_rate_limiter
  import tbrl_pkg::*;
#(
  parameter int unsigned NUM_USERS = DEF_NUM_USERS,
  parameter int unsigned TIME_BITS = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [USER_W-1:0]      user_index,
  input  logic [NOW_W-1:0]       now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   allowed,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  tbrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tbrl_dp #(
    .NUM_USERS (NUM_USERS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .user_index (user_index),
    .now_ms     (now_ms),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .allowed    (allowed)
  );

  // at most one datapath step per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.calc1, cmd.calc2, cmd.commit}))
    else $error("more than one datapath command at once");

  // never overwrite a result the receiver has not taken
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // a request transaction is followed by the multiply step
  a_load_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (cmd.calc1 && in_stall))
    else $error("request not followed by multiply step");

  // a new result appears only from a commit
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result without commit");

endmodule
